// ===== rtl/pli_pkg.sv =====
// shared types and constants for the positional list engine
package pli_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 7;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,
    SH_DOWN
  } shift_t;

  typedef struct packed {
    shift_t           shift;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== rtl/pli_cell.sv =====
// one list slot: holds an element and shifts it to or from its neighbors
module pli_cell #(
  parameter int ELEM_WIDTH = pli_pkg::ELEM_WIDTH_DEF,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  pli_pkg::cell_ctrl_t   ctrl,
  input  logic [ELEM_WIDTH-1:0] ins_value,
  input  logic [ELEM_WIDTH-1:0] left_value,
  input  logic [ELEM_WIDTH-1:0] right_value,
  output logic [ELEM_WIDTH-1:0] entry
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = (INDEX == int'(ctrl.pos));
  assign above_pos = (INDEX > int'(ctrl.pos));

  always_ff @(posedge clk) begin
    case (ctrl.shift)
      pli_pkg::SH_UP: begin
        if (at_pos) begin
          entry <= ins_value;
        end else if (above_pos) begin
          entry <= left_value;
        end
      end
      pli_pkg::SH_DOWN: begin
        if (at_pos || above_pos) begin
          entry <= right_value;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

// ===== rtl/pli_read_tree.sv =====
// registered or-tree that picks the element at one position out of the cell row
module pli_read_tree #(
  parameter int DEPTH      = pli_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = pli_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic [DEPTH-1:0][ELEM_WIDTH-1:0]    entries,
  input  logic [pli_pkg::POS_W-1:0]           pos,
  output logic [ELEM_WIDTH-1:0]               root
);

  localparam int LEVELS = $clog2(DEPTH);
  localparam int LEAVES = 1 << LEVELS;

  logic [ELEM_WIDTH-1:0] leaf [LEAVES];
  logic [ELEM_WIDTH-1:0] node [1:LEAVES-1];

  // only the addressed slot reaches the tree, all others read as zero
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < DEPTH) begin : g_real
      assign leaf[i] = (int'(pos) == i) ? entries[i] : '0;
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    if (2 * n >= LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node[n] <= leaf[2*n-LEAVES] | leaf[2*n+1-LEAVES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[n] <= node[2*n] | node[2*n+1];
      end
    end
  end

  assign root = node[1];

endmodule

// ===== rtl/positional_list_engine_core.sv =====
// top level of the positional list engine: control, cell row and read tree
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tuser opcode; tdata position, value_in
//  m_      | out | m_tvalid/m_tready | tuser status; tdata value_out, list_length, is_empty
//
// one request at a time; after accept the block waits in the busy state while the
// read tree settles, then offers the result in the output state before the next
// accept; the busy wait is set by the depth of the registered read tree
// rst clears the length and the control; element contents stay unknown
// a stalled result holds the block, s_tready stays low until it is taken
module positional_list_engine_core #(
  parameter int DEPTH      = pli_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = pli_pkg::ELEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pli_pkg::S_DATA_W-1:0]  s_tdata,  // position[6:0], value_in[38:7]
  input  logic [pli_pkg::OP_W-1:0]      s_tuser,  // opcode[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pli_pkg::M_DATA_W-1:0]  m_tdata,  // value_out[31:0], list_length[38:32], is_empty[39]
  output logic [pli_pkg::STAT_W-1:0]    m_tuser   // status[1:0]
);

  localparam int LEVELS = $clog2(DEPTH);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W;

  pli_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [LVL_W-1:0]  wait_cnt;
  pli_pkg::status_t  status_q;
  logic              has_value_q;

  logic [pli_pkg::VAL_W-1:0] out_value;
  pli_pkg::status_t          out_status;
  logic [pli_pkg::LEN_W-1:0] out_len;
  logic                      out_empty;

  logic                          s_acc;
  logic                          load_out;
  pli_pkg::op_t                  op;
  logic [pli_pkg::POS_W-1:0]     pos;
  logic [pli_pkg::VAL_W-1:0]     val;
  logic [ELEM_WIDTH-1:0]         ins_elem;
  logic [CMP_W-1:0]              pos_ext;
  logic [CMP_W-1:0]              cnt_ext;
  pli_pkg::status_t              status_c;
  logic                          has_value_c;
  pli_pkg::cell_ctrl_t           ctrl;

  logic [DEPTH-1:0][ELEM_WIDTH-1:0] cell_q;
  logic [ELEM_WIDTH-1:0]            root;

  assign op       = pli_pkg::op_t'(s_tuser);
  assign pos      = s_tdata[pli_pkg::POS_W-1:0];
  assign val      = s_tdata[pli_pkg::POS_W +: pli_pkg::VAL_W];
  assign ins_elem = ELEM_WIDTH'(64'(val));
  assign pos_ext  = CMP_W'(pos);
  assign cnt_ext  = CMP_W'(count);
  assign s_acc    = s_tvalid && s_tready;

  // request check and shift command for the cell row
  always_comb begin
    status_c    = pli_pkg::ST_OK;
    has_value_c = 1'b0;
    ctrl.pos    = pos;
    ctrl.shift  = pli_pkg::SH_NONE;
    unique case (op)
      pli_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_c = pli_pkg::ST_RANGE;
        end else if (cnt_ext >= CMP_W'(DEPTH)) begin
          status_c = pli_pkg::ST_FULL;
        end else if (s_acc) begin
          ctrl.shift = pli_pkg::SH_UP;
        end
      end
      pli_pkg::OP_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status_c = pli_pkg::ST_RANGE;
        end else begin
          has_value_c = 1'b1;
          if (s_acc) begin
            ctrl.shift = pli_pkg::SH_DOWN;
          end
        end
      end
      default: begin
        // unused opcode acts as a read
        if (pos_ext >= cnt_ext) begin
          status_c = pli_pkg::ST_RANGE;
        end else begin
          has_value_c = 1'b1;
        end
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_v;
    logic [ELEM_WIDTH-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_q[i+1];
    end
    pli_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .ins_value   (ins_elem),
      .left_value  (left_v),
      .right_value (right_v),
      .entry       (cell_q[i])
    );
  end

  // the tree samples the row at the accept edge, before the shift lands
  pli_read_tree #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_tree (
    .clk     (clk),
    .entries (cell_q),
    .pos     (pos),
    .root    (root)
  );

  assign load_out = (state == pli_pkg::S_BUSY) && (wait_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pli_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      pli_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = pli_pkg::S_BUSY;
        end
      end
      pli_pkg::S_BUSY: begin
        if (wait_cnt == '0) begin
          state_next = pli_pkg::S_OUT;
        end
      end
      pli_pkg::S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = pli_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pli_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wait_cnt <= '0;
    end else begin
      if (s_acc) begin
        wait_cnt <= LVL_W'(LEVELS - 1);
        if (ctrl.shift == pli_pkg::SH_UP) begin
          count <= count + 1'b1;
        end else if (ctrl.shift == pli_pkg::SH_DOWN) begin
          count <= count - 1'b1;
        end
      end else if (state == pli_pkg::S_BUSY && wait_cnt != '0) begin
        wait_cnt <= wait_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      status_q    <= status_c;
      has_value_q <= has_value_c;
    end
    if (load_out) begin
      out_value  <= has_value_q ? pli_pkg::VAL_W'(64'(root)) : '0;
      out_status <= status_q;
      out_len    <= pli_pkg::LEN_W'(count);
      out_empty  <= (count == '0);
    end
  end

  assign m_tdata = {out_empty, out_len, out_value};
  assign m_tuser = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("list length exceeds capacity");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (s_acc && status_c != pli_pkg::ST_OK) |=> count == $past(count))
    else $error("rejected request changed the length");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (s_acc && op == pli_pkg::OP_INSERT && status_c == pli_pkg::ST_OK)
      |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the list");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == pli_pkg::S_BUSY)
    else $error("result shown without a pending request");

endmodule
